// ===== design/masked_byte_pattern_search_macros.svh =====
// Assertion macros for the masked byte pattern search block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH
`define MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH

// Clocked check, muted while reset is high.
`define MBPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Clocked check that also holds through reset.
`define MBPS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== design/mbps_pkg.sv =====
// Shared types and constants for the masked byte pattern search block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

   localparam int MAX_PATTERN_DEFAULT = 32;

   localparam int BYTE_W        = 8;
   localparam int PAT_BYTES     = 32;   // pattern bytes held in the registers
   localparam int PAT_IDX_W     = 5;    // index into the pattern bytes
   localparam int PAT_REGS      = 4;
   localparam int BYTES_PER_REG = 8;
   localparam int POS_W         = 7;    // holds 0..127, any window position or length
   localparam int LEN_W         = 6;
   localparam int MASK_W        = 32;
   localparam int COUNT_W       = 32;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_0      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_1      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_2      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_3      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPARE_MASK   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 3'd5;

   typedef logic [BYTE_W-1:0] byte_type;

endpackage

`default_nettype wire

// ===== design/masked_byte_pattern_search.sv =====
// Top level of the masked byte pattern search block.
// Depends on mbps_pkg, mbps_window_match and masked_byte_pattern_search_macros.svh.
//
// Usage:
//   req_* carries one byte word per handshake with a last-byte flag closing
//   each buffer. rsp_* returns at most one word per buffer: found with the
//   start offset of the first masked match, or not-found (offset 0) at the
//   last byte when nothing matched. Bytes after a report are swallowed.
//   csr_* writes the pattern, compare mask and length; write only when idle.
// Timing:
//   The result is registered at the edge that accepts the byte, and rsp_*
//   is driven straight from that register. One byte is taken every cycle
//   unless req_ready is low; the compare of the shifted window against the
//   pattern sits between the window register and the result register.
// Stall:
//   req_ready drops only when the result register is full and rsp_ready is
//   low; a byte that causes no result still needs that register free.
// Reset:
//   Clears config registers, the byte count, the reported flag and the
//   result valid. The window is not cleared: only bytes of the current
//   count are ever compared.
`timescale 1ns / 1ps
`default_nettype none
`include "masked_byte_pattern_search_macros.svh"

module masked_byte_pattern_search
   import mbps_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [BYTE_W-1:0]      req_data_byte,
   input  wire logic                   req_last_byte,

   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_found,
   output logic [COUNT_W-1:0]          rsp_match_offset,

   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   // ---------------------------------------------------------------
   // Config registers
   // ---------------------------------------------------------------
   logic [CSR_DATA_W-1:0] pat_ff [PAT_REGS];
   logic [MASK_W-1:0]     mask_ff;
   logic [LEN_W-1:0]      len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < PAT_REGS; r++) begin
            pat_ff[r] <= '0;
         end
         mask_ff <= '0;
         len_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_0:      pat_ff[0] <= csr_write_data;
            CSR_PATTERN_1:      pat_ff[1] <= csr_write_data;
            CSR_PATTERN_2:      pat_ff[2] <= csr_write_data;
            CSR_PATTERN_3:      pat_ff[3] <= csr_write_data;
            CSR_COMPARE_MASK:   mask_ff   <= csr_write_data[MASK_W-1:0];
            CSR_PATTERN_LENGTH: len_ff    <= csr_write_data[LEN_W-1:0];
            default: ;  // unused indexes are dropped
         endcase
      end
   end

   // Unpack pattern bytes: byte k lives in register k/8 at bit 8*(k%8).
   byte_type pat_byte [PAT_BYTES];
   for (genvar k = 0; k < PAT_BYTES; k++) begin : g_pat
      assign pat_byte[k] =
         pat_ff[k / BYTES_PER_REG][(k % BYTES_PER_REG) * BYTE_W +: BYTE_W];
   end

   // Length clamped to the window depth.
   logic [POS_W-1:0] match_len;
   assign match_len = (POS_W'(len_ff) > POS_W'(MAX_PATTERN))
                    ? POS_W'(MAX_PATTERN) : POS_W'(len_ff);

   // ---------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------
   logic rsp_valid_ff;
   logic req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // ---------------------------------------------------------------
   // Byte window: shift in the new byte, newest at entry 0
   // ---------------------------------------------------------------
   byte_type window_ff [MAX_PATTERN];
   byte_type window_in [MAX_PATTERN];

   assign window_in[0] = req_data_byte;
   for (genvar w = 1; w < MAX_PATTERN; w++) begin : g_shift
      assign window_in[w] = window_ff[w-1];
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int w = 0; w < MAX_PATTERN; w++) begin
            window_ff[w] <= window_in[w];
         end
      end
   end

   // Compare runs on the window as it will be after this byte.
   logic window_hit;

   mbps_window_match #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_match (
      .window       (window_in),
      .pattern      (pat_byte),
      .compare_mask (mask_ff),
      .match_length (match_len),
      .window_hit   (window_hit)
   );

   // ---------------------------------------------------------------
   // Byte count and match tracking
   // ---------------------------------------------------------------
   logic [COUNT_W-1:0] bytes_seen_ff, bytes_seen_in;
   logic               match_reported_ff, match_reported_in;
   logic [COUNT_W-1:0] seen_inc;
   logic               count_en;
   logic               match_now;
   logic               emit;

   assign seen_inc  = bytes_seen_ff + COUNT_W'(1);
   // Counting stops after a report and at saturation; no compare then.
   assign count_en  = !match_reported_ff && (bytes_seen_ff != '1);
   assign match_now = count_en && (match_len != '0)
                   && (seen_inc >= COUNT_W'(match_len)) && window_hit;
   // Not-found goes out at the last byte unless something was reported.
   assign emit      = match_now || (req_last_byte && !match_reported_ff);

   always_comb begin
      bytes_seen_in     = bytes_seen_ff;
      match_reported_in = match_reported_ff;
      if (req_fire) begin
         if (count_en) begin
            bytes_seen_in = seen_inc;
         end
         if (match_now) begin
            match_reported_in = 1'b1;
         end
         if (req_last_byte) begin  // re-arm for the next buffer
            bytes_seen_in     = '0;
            match_reported_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff     <= '0;
         match_reported_ff <= 1'b0;
      end else begin
         bytes_seen_ff     <= bytes_seen_in;
         match_reported_ff <= match_reported_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic               rsp_found_ff;
   logic [COUNT_W-1:0] rsp_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         rsp_found_ff  <= match_now;
         rsp_offset_ff <= match_now ? (seen_inc - COUNT_W'(match_len)) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   `MBPS_ASSERT(a_no_overwrite, req_fire && emit |-> !rsp_valid_ff || rsp_ready, "result register overwritten while held")
   `MBPS_ASSERT(a_single_report, req_fire && match_reported_ff |-> !match_now, "second match reported in one buffer")
   `MBPS_ASSERT(a_rearm, req_fire && req_last_byte |=> bytes_seen_ff == '0 && !match_reported_ff, "tracking not re-armed after last byte")
   `MBPS_ASSERT(a_notfound_zero, rsp_valid_ff && !rsp_found_ff |-> rsp_offset_ff == '0, "not-found result carries an offset")

endmodule

`default_nettype wire

// ===== design/mbps_window_match.sv =====
// Masked compare of the byte window against the pattern for a given length.
// Depends on mbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbps_window_match
   import mbps_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
   input  var byte_type          window [MAX_PATTERN],  // entry 0 is newest
   input  var byte_type          pattern [PAT_BYTES],
   input  wire logic [MASK_W-1:0] compare_mask,
   input  wire logic [POS_W-1:0]  match_length,          // already clamped
   output logic                   window_hit
);

   logic [POS_W-1:0]       pos [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] pos_ok;

   // Window entry i lines up with pattern byte length-1-i.
   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pos
      assign pos[i] = match_length - POS_W'(i) - POS_W'(1);
      assign pos_ok[i] = (POS_W'(i) >= match_length)
                      || (pos[i] >= POS_W'(PAT_BYTES))
                      || !compare_mask[pos[i][PAT_IDX_W-1:0]]
                      || (window[i] == pattern[pos[i][PAT_IDX_W-1:0]]);
   end

   assign window_hit = &pos_ok;

endmodule

`default_nettype wire

// ===== test/masked_byte_pattern_search_tb.sv =====
// Self-checking testbench for masked_byte_pattern_search: random byte buffers vs. a predictor.
// Depends on mbps_pkg and the masked_byte_pattern_search RTL.
`timescale 1ns / 1ps

module masked_byte_pattern_search_tb
   import mbps_pkg::*;
();

   // Window depth of the instance; pattern positions at or past PAT_BYTES are wildcards.
   localparam int WIN          = MAX_PATTERN_DEFAULT;
   localparam int IDLE_PCT     = 24;      // idle odds per cycle, both sides
   localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
   localparam int TAIL_CYCLES  = 4;       // settle's final wait once the results have drained
   localparam int DRAIN_LIMIT  = 4000;
   localparam int RANDOM_WORDS = 550;
   localparam int MAX_REPORTS  = 30;
   localparam int TIMEOUT_NS   = 2_000_000;

   typedef struct packed {
      logic               found;
      logic [COUNT_W-1:0] offset;
   } search_result_type;

   // Predicts search results from accepted bytes and checks what comes out.
   class search_scoreboard_type;
      logic [CSR_DATA_W-1:0] pattern_reg [PAT_REGS];
      logic [MASK_W-1:0]     mask_reg;
      logic [LEN_W-1:0]      length_reg;
      byte_type              window [WIN];
      logic [COUNT_W-1:0]    bytes_seen;
      bit                    reported;
      search_result_type     expected_results [$];
      int                    mismatch_count;
      int                    results_seen;

      function new();
         int k;
         for (k = 0; k < PAT_REGS; k++) pattern_reg[k] = '0;
         for (k = 0; k < WIN; k++) window[k] = '0;
         mask_reg       = '0;
         length_reg     = '0;
         bytes_seen     = '0;
         reported       = 1'b0;
         mismatch_count = 0;
         results_seen   = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_PATTERN_0, CSR_PATTERN_1,
            CSR_PATTERN_2, CSR_PATTERN_3: pattern_reg[index] = data;
            CSR_COMPARE_MASK:             mask_reg = data[MASK_W-1:0];
            CSR_PATTERN_LENGTH:           length_reg = data[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      // Lengths above the window depth are clamped.
      function int span();
         return (int'(length_reg) > WIN) ? WIN : int'(length_reg);
      endfunction

      function bit required(int j);
         return (j < PAT_BYTES) && mask_reg[j];
      endfunction

      function byte_type pattern_byte(int j);
         return pattern_reg[j / BYTES_PER_REG][BYTE_W * (j % BYTES_PER_REG) +: BYTE_W];
      endfunction

      // Oldest byte of the window lines up with pattern byte 0.
      function bit window_hit(int n);
         int j;
         for (j = 0; j < n; j++) begin
            if (!required(j)) continue;
            if (window[n - 1 - j] !== pattern_byte(j)) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void take_byte(byte_type data, logic last);
         int n;
         int i;
         bit hit;
         search_result_type item;
         n = span();
         hit = 1'b0;
         for (i = WIN - 1; i > 0; i--) window[i] = window[i - 1];
         window[0] = data;
         // count stops at all ones; no compare once it does
         if (!reported && bytes_seen != {COUNT_W{1'b1}}) begin
            bytes_seen++;
            if (n > 0 && bytes_seen >= COUNT_W'(n) && window_hit(n)) begin
               reported = 1'b1;
               hit = 1'b1;
               item.found  = 1'b1;
               item.offset = bytes_seen - COUNT_W'(n);
               expected_results.insert(expected_results.size(), item);
            end
         end
         if (last) begin
            if (!hit && !reported) begin
               item.found  = 1'b0;
               item.offset = '0;
               expected_results.insert(expected_results.size(), item);
            end
            bytes_seen = '0;
            reported   = 1'b0;
         end
      endfunction

      task report_mismatch(string msg);
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
      endtask

      task check_result(logic found, logic [COUNT_W-1:0] offset);
         search_result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result found=%0b offset=%0d", found, offset));
            return;
         end
         want = expected_results.pop_front();
         results_seen++;
         if (found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", found, want.found));
         if (offset !== want.offset)
            report_mismatch($sformatf("offset %0d, expected %0d", offset, want.offset));
      endtask

      task flush_leftovers();
         while (expected_results.size() != 0) begin
            report_mismatch($sformatf("result never arrived: found=%0b offset=%0d",
                                      expected_results[0].found, expected_results[0].offset));
            void'(expected_results.pop_front());
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [BYTE_W-1:0]      req_data_byte = '0;
   logic                   req_last_byte = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_found;
   logic [COUNT_W-1:0]     rsp_match_offset;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   search_scoreboard_type sb;
   bit               steady_flow = 1'b0;        // both sides run without gaps
   bit               hold_off_request = 1'b0;   // asks the sink for one long stall
   int               words_sent = 0;

   masked_byte_pattern_search u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   // Result sink: checks each accepted word, then picks next cycle's ready.
   // A hold-off request drops ready and keeps it low while a counter loaded
   // from HOLD_CYCLES runs down here, so the result register fills and the block has to stall its input.
   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
            sb.check_result(rsp_found, rsp_match_offset);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (steady_flow) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Offers one byte word; returns in the step of the edge that took it.
   // valid is left high so a back-to-back word needs only one assignment.
   task automatic send_word(input byte_type data, input logic last);
      if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PCT);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.take_byte(data, last);
      words_sent++;
   endtask

   // Drop valid, wait out every expected result, then the pipeline tail.
   task automatic settle();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (sb.expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      sb.write_reg(index, data);
   endtask

   // Writes all six registers back to back; only called with the block idle.
   task automatic program_search(input logic [CSR_DATA_W-1:0] p0, input logic [CSR_DATA_W-1:0] p1,
                                 input logic [CSR_DATA_W-1:0] p2, input logic [CSR_DATA_W-1:0] p3,
                                 input logic [CSR_DATA_W-1:0] mask_word,
                                 input logic [CSR_DATA_W-1:0] length_word);
      write_csr(CSR_PATTERN_0, p0);
      write_csr(CSR_PATTERN_1, p1);
      write_csr(CSR_PATTERN_2, p2);
      write_csr(CSR_PATTERN_3, p3);
      write_csr(CSR_COMPARE_MASK, mask_word);
      write_csr(CSR_PATTERN_LENGTH, length_word);
      csr_write_enable <= 1'b0;
   endtask

   // One buffer: mostly noise + a pattern instance + noise, some with a
   // required byte broken, some shorter than the pattern, some pure noise.
   // With close clear the buffer is left open for the next config.
   task automatic send_random_buffer(input bit close);
      byte_type line [$];
      int       n;
      int       style;
      int       base;
      int       k;
      int       pick;
      n = sb.span();
      style = $urandom_range(99);
      repeat ($urandom_range(0, 6)) line.insert(line.size(), byte_type'($urandom));
      if (n == 0 || style >= 90) begin
         repeat ($urandom_range(1, 10)) line.insert(line.size(), byte_type'($urandom));
      end else if (style < 75) begin
         base = line.size();
         for (k = 0; k < n; k++)
            line.insert(line.size(),
                        sb.required(k) ? sb.pattern_byte(k) : byte_type'($urandom));
         if (style >= 60) begin
            pick = $urandom_range(0, n - 1);
            if (sb.required(pick))
               line[base + pick] = line[base + pick] ^ (byte_type'(1) << $urandom_range(0, 7));
         end
         repeat ($urandom_range(0, 4)) line.insert(line.size(), byte_type'($urandom));
      end else begin
         line.delete();
         repeat ($urandom_range(1, (n > 1) ? n - 1 : 1))
            line.insert(line.size(), byte_type'($urandom));
      end
      for (k = 0; k < line.size(); k++)
         send_word(line[k], close && (k == line.size() - 1));
   endtask

   initial begin : stimulus
      int                    phase;
      int                    kind;
      int                    buffers;
      int                    k;
      logic [CSR_DATA_W-1:0] pat [PAT_REGS];
      logic [CSR_DATA_W-1:0] mask_word;
      logic [CSR_DATA_W-1:0] length_word;

      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers at reset: zero length, never matches.
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);
      settle();

      // Two-byte pattern AB CD, all bytes required.
      program_search(64'h0000_0000_0000_CDAB, '0, '0, '1, '1, 64'd2);
      // match closes on the last byte: one found word, no not-found
      send_word(8'h00, 1'b0);
      send_word(8'hAB, 1'b0);
      send_word(8'hCD, 1'b1);
      // match at offset 0; the rest of the buffer is swallowed
      send_word(8'hAB, 1'b0);
      send_word(8'hCD, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);
      // buffer shorter than the pattern
      send_word(8'hAB, 1'b1);
      settle();

      // All wildcards: first full window hits at offset 0.
      program_search('1, '1, '1, '1, 64'hFFFF_FFFF_0000_0000, 64'd3);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h5A, 1'b0);
      send_word(8'h00, 1'b1);
      settle();

      // Oversized length (clamped), then a new config in the middle of a buffer.
      program_search('0, '0, '0, '0, '1, 64'd63);
      send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b0);
      settle();
      program_search('0, '0, '0, '0, 64'd1, 64'd1);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b1);
      settle();

      // Random phases, each with its own config. Phase 1 carries the long
      // receiver hold-off, phase 3 runs with no idling on either side.
      words_sent = 0;
      phase = 0;
      while (words_sent < RANDOM_WORDS) begin
         kind = phase % 6;
         for (k = 0; k < PAT_REGS; k++) pat[k] = {$urandom, $urandom};
         mask_word   = {$urandom, $urandom};
         length_word = {$urandom, $urandom};
         mask_word[MASK_W-1:0] = $urandom | $urandom;   // mostly required bytes
         case (kind)
            0: length_word[LEN_W-1:0] = LEN_W'($urandom_range(1, 6));
            1: length_word[LEN_W-1:0] = LEN_W'(PAT_BYTES);
            2: length_word[LEN_W-1:0] = LEN_W'($urandom_range(PAT_BYTES + 1, 63));
            3: begin
               mask_word[MASK_W-1:0] = '0;
               length_word[LEN_W-1:0] = LEN_W'($urandom_range(1, 8));
            end
            4: length_word[LEN_W-1:0] = '0;
            default: begin
               // extreme bytes only: pattern all 00 or all FF, every byte required
               for (k = 0; k < PAT_REGS; k++) pat[k] = {CSR_DATA_W{phase[1]}};
               mask_word[MASK_W-1:0] = '1;
               length_word[LEN_W-1:0] = LEN_W'($urandom_range(1, 4));
            end
         endcase
         program_search(pat[0], pat[1], pat[2], pat[3], mask_word, length_word);

         steady_flow = (phase == 3);
         if (phase == 1) hold_off_request = 1'b1;
         buffers = (sb.span() > 8) ? $urandom_range(2, 3) : $urandom_range(4, 9);
         for (k = 0; k < buffers && words_sent < RANDOM_WORDS; k++) send_random_buffer(1'b1);
         if ($urandom_range(99) < 30) send_random_buffer(1'b0);
         settle();
         steady_flow = 1'b0;
         phase++;
      end

      // Close any buffer still open so its outcome is checked too.
      send_word(byte_type'($urandom), 1'b1);
      settle();
      sb.flush_leftovers();
      if (sb.mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/mbps_pkg.sv
design/mbps_window_match.sv
design/masked_byte_pattern_search.sv
test/masked_byte_pattern_search_tb.sv
